@@ src/aes_pkg.sv @@
package aes_pkg;

  localparam int unsigned NumCols   = 4;
  localparam int unsigned MaxRounds = 14;
  localparam int unsigned NumRk     = MaxRounds + 1;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  typedef logic [127:0] state_t;
  typedef logic [31:0]  word_t;

  typedef enum logic [1:0] {
    KeyLen128 = 2'd0,
    KeyLen192 = 2'd1,
    KeyLen256 = 2'd2,
    KeyLenAlt = 2'd3
  } key_len_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyLen = 3'd0,
    RegKey0   = 3'd1,
    RegKey1   = 3'd2,
    RegKey2   = 3'd3,
    RegKey3   = 3'd4
  } cfg_reg_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(word_t w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte k of the state sits at bits 127-8k
  function automatic state_t sub_shift(state_t s);
    state_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic state_t mix_cols(state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

endpackage

@@ src/aes_if.sv @@
interface aes_if #(
  parameter int unsigned Width = 64
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] hi;
  logic [Width-1:0] lo;

  modport source (output valid, output hi, output lo, input ready);
  modport sink (input valid, input hi, input lo, output ready);
endinterface

@@ src/aes_key_exp.sv @@
// full key schedule expanded at configuration time, one word per cycle
module aes_key_exp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [1:0]                         key_len_i,
  input  logic [255:0]                       key_i,
  output logic [aes_pkg::NumRk*128-1:0]      rk_o,
  output logic [3:0]                         nr_o,
  output logic                               busy_o
);
  localparam int unsigned NWords = aes_pkg::NumCols * aes_pkg::NumRk;

  logic [31:0] w_q [NWords];
  logic [5:0]  idx_q, idx_d;
  logic [3:0]  nk_q, nk_d, cnt_q, cnt_d;
  logic [7:0]  rc_q, rc_d;
  logic        busy_q, busy_d;
  logic [31:0] t, wnew;
  logic [3:0]  nr_q, nr_d;

  always_comb begin
    nk_d = nk_q;
    nr_d = nr_q;
    if (start_i) begin
      unique case (aes_pkg::key_len_e'(key_len_i))
        aes_pkg::KeyLen128: begin nk_d = 4'd4; nr_d = 4'd10; end
        aes_pkg::KeyLen192: begin nk_d = 4'd6; nr_d = 4'd12; end
        aes_pkg::KeyLen256, aes_pkg::KeyLenAlt: begin nk_d = 4'd8; nr_d = 4'd14; end
        default: begin nk_d = 4'd8; nr_d = 4'd14; end
      endcase
    end
  end

  always_comb begin
    t = w_q[idx_q[5:0] - 6'd1];
    if (cnt_q == 4'd0) begin
      t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    end else if (nk_q == 4'd8 && cnt_q == 4'd4) begin
      t = aes_pkg::sub_word(t);
    end
    wnew = w_q[idx_q - 6'(nk_q)] ^ t;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    rc_d   = rc_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = 6'(nk_d);
      cnt_d  = 4'd0;
      rc_d   = 8'h01;
    end else if (busy_q) begin
      idx_d = idx_q + 6'd1;
      cnt_d = (cnt_q == nk_q - 4'd1) ? 4'd0 : cnt_q + 4'd1;
      if (cnt_q == 4'd0) rc_d = aes_pkg::xtime(rc_q);
      if (idx_q == 6'(NWords - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
      rc_q   <= 8'h01;
      nk_q   <= 4'd4;
      nr_q   <= 4'd10;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      rc_q   <= rc_d;
      nk_q   <= nk_d;
      nr_q   <= nr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) w_q[i] <= key_i[255-32*i -: 32];
    end else if (busy_q) begin
      w_q[idx_q] <= wnew;
    end
  end

  always_comb begin
    for (int i = 0; i < NWords; i++) rk_o[aes_pkg::NumRk*128-1-32*i -: 32] = w_q[i];
  end

  assign nr_o   = nr_q;
  assign busy_o = busy_q | start_i;
endmodule

@@ src/aes_round.sv @@
// one pipeline stage: one round, or pass-through past the last round
module aes_round #(
  parameter int unsigned Round = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  aes_pkg::state_t     state_i,
  input  aes_pkg::state_t     rk_i,
  input  logic [3:0]          nr_i,
  output logic                valid_o,
  output aes_pkg::state_t     state_o
);
  aes_pkg::state_t ss, st_d, st_q;
  logic            vld_q;

  always_comb begin
    ss = aes_pkg::sub_shift(state_i);
    if (4'(Round) < nr_i)       st_d = aes_pkg::mix_cols(ss) ^ rk_i;
    else if (4'(Round) == nr_i) st_d = ss ^ rk_i;
    else                        st_d = state_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign valid_o = vld_q;
  assign state_o = st_q;
endmodule

@@ src/aes_block_encrypt.sv @@
// channel  | dir | payload                | beat when
// in_if    | in  | block_high, block_low  | valid && ready
// out_if   | out | cipher_high, cipher_low| valid && ready
// cfg      | in  | cfg_we_i/idx/data      | cfg_we_i high
//
// initial key add stage plus 14 round stages; shorter keys pass the unused
// tail stages through unchanged. one block per cycle unless stalled or the
// key table is rebuilt. the whole pipeline advances together; ready is high
// when no expansion runs and the output stage is empty or being taken, so a
// stall freezes every stage with nothing lost. a key write restarts the
// expansion on the shared word unit, and input is held off until the round
// key table is complete. reset clears all valid bits and the key registers.
module aes_block_encrypt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aes_pkg::CfgDataW-1:0]  cfg_data_i,
  aes_if.sink                           in_if,
  aes_if.source                         out_if
);
  localparam int unsigned NR = aes_pkg::MaxRounds;

  logic [1:0]   klen_q;
  logic [63:0]  key_q [4];
  logic         start_q;
  logic [aes_pkg::NumRk*128-1:0] rk;
  logic [3:0]   nr;
  logic         kbusy;
  logic         en;

  // config registers; expansion kicks off the cycle after a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= 2'd0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      start_q <= 1'b1;
    end else begin
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          aes_pkg::RegKeyLen: klen_q   <= cfg_data_i[1:0];
          aes_pkg::RegKey0:   key_q[0] <= cfg_data_i;
          aes_pkg::RegKey1:   key_q[1] <= cfg_data_i;
          aes_pkg::RegKey2:   key_q[2] <= cfg_data_i;
          aes_pkg::RegKey3:   key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  aes_key_exp u_kexp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .key_len_i (klen_q),
    .key_i     ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .rk_o      (rk),
    .nr_o      (nr),
    .busy_o    (kbusy)
  );

  // stage chain: index 0 is the initial key add
  logic            vld [NR+1];
  aes_pkg::state_t st  [NR+1];
  logic            v0_q;
  aes_pkg::state_t s0_q;

  assign en          = !vld[NR] || out_if.ready;
  assign in_if.ready = en && !kbusy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_if.valid && !kbusy;
  end

  always_ff @(posedge clk_i) begin
    if (en) s0_q <= {in_if.hi, in_if.lo} ^ rk[aes_pkg::NumRk*128-1 -: 128];
  end

  assign vld[0] = v0_q;
  assign st[0]  = s0_q;

  for (genvar r = 1; r <= NR; r++) begin : g_round
    aes_round #(.Round(r)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[r-1]),
      .state_i (st[r-1]),
      .rk_i    (rk[aes_pkg::NumRk*128-1-128*r -: 128]),
      .nr_i    (nr),
      .valid_o (vld[r]),
      .state_o (st[r])
    );
  end

  assign out_if.valid = vld[NR];
  assign out_if.hi    = st[NR][127:64];
  assign out_if.lo    = st[NR][63:0];

  // no input beat while the key table is being rebuilt
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kbusy |-> !in_if.ready) else $error("input taken during key expansion");

  // a stall freezes the output stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.hi)))
    else $error("output changed under stall");

  // pipeline moves whenever output is free
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> en) else $error("pipeline stuck");
endmodule

@@ dv/aes_block_encrypt_tb.sv @@
`timescale 1ns / 100ps

module aes_block_encrypt_tb;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [aes_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [aes_pkg::CfgDataW-1:0] cfg_data_i;

  aes_if #(.Width(64)) in_if ();
  aes_if #(.Width(64)) out_if ();

  aes_block_encrypt uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // cipher block as it should leave the block
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_t;

  // own copy of the key registers
  aes_pkg::key_len_e cur_len;
  logic [63:0]       cur_key [4];

  cipher_t     cipher_q [$];
  int          errors;
  int          cycles;
  bit          sink_jitter;
  bit          hold_off;

  localparam int CycleLimit = 400000;
  localparam int Latency    = 15;
  // key schedule restart after a write, with margin
  localparam int KeyWait    = 80;

  // plain table of the s-box, kept apart from the design's copy
  localparam logic [7:0] SubTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {SubTab[w[31:24]], SubTab[w[23:16]], SubTab[w[15:8]], SubTab[w[7:0]]};
  endfunction

  // full encryption of one block under the current key registers
  function automatic cipher_t encrypt_block(logic [63:0] hi, logic [63:0] lo);
    logic [31:0]  rk [60];
    logic [7:0]   st [16];
    logic [7:0]   tmp [16];
    logic [7:0]   rcon;
    logic [31:0]  t;
    logic [255:0] key;
    logic [7:0]   a0, a1, a2, a3, al;
    int           nk, nr;
    cipher_t      res;
    rcon = 8'h01;
    key  = {cur_key[0], cur_key[1], cur_key[2], cur_key[3]};
    case (cur_len)
      aes_pkg::KeyLen128: begin nk = 4; nr = 10; end
      aes_pkg::KeyLen192: begin nk = 6; nr = 12; end
      default:            begin nk = 8; nr = 14; end
    endcase
    for (int i = 0; i < nk; i++) rk[i] = key[255-32*i -: 32];
    for (int i = nk; i < 4*(nr+1); i++) begin
      t = rk[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      rk[i] = rk[i-nk] ^ t;
    end
    for (int i = 0; i < 8; i++) begin
      st[i]   = hi[63-8*i -: 8];
      st[8+i] = lo[63-8*i -: 8];
    end
    for (int r = 0; r <= nr; r++) begin
      if (r > 0) begin
        // sub bytes and shift rows together
        for (int c = 0; c < 4; c++)
          for (int b = 0; b < 4; b++) tmp[4*c+b] = SubTab[st[4*((c+b)%4)+b]];
        st = tmp;
        if (r < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int b = 0; b < 4; b++) st[4*c+b] ^= rk[4*r+c][31-8*b -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d blocks outstanding", $time, cipher_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // register write, only while the pipe is empty
  task automatic write_reg(aes_pkg::cfg_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    // model keeps only known indexes
    case (idx)
      aes_pkg::RegKeyLen: cur_len = aes_pkg::key_len_e'(data[1:0]);
      aes_pkg::RegKey0:   cur_key[0] = data;
      aes_pkg::RegKey1:   cur_key[1] = data;
      aes_pkg::RegKey2:   cur_key[2] = data;
      aes_pkg::RegKey3:   cur_key[3] = data;
      default: ;
    endcase
  endtask

  // out-of-range index: block must ignore it
  task automatic write_bad_idx(logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 3'd5 + 3'($urandom_range(0, 2));
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic drain();
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic set_key(aes_pkg::key_len_e len, logic [63:0] k0, logic [63:0] k1,
                         logic [63:0] k2, logic [63:0] k3);
    drain();
    write_reg(aes_pkg::RegKeyLen, 64'(len));
    write_reg(aes_pkg::RegKey0, k0);
    write_reg(aes_pkg::RegKey1, k1);
    write_reg(aes_pkg::RegKey2, k2);
    write_reg(aes_pkg::RegKey3, k3);
    repeat (KeyWait) @(negedge clk_i);
  endtask

  // one input beat; stays high into the next beat when no idle cycle is drawn
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit jitter);
    in_if.valid <= 1'b1;
    in_if.hi    <= hi;
    in_if.lo    <= lo;
    do @(posedge clk_i); while (!in_if.ready);
    cipher_q.push_back(encrypt_block(hi, lo));
    @(negedge clk_i);
    if (jitter) begin
      while ($urandom_range(0, 99) < 37) begin
        in_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic stop_source();
    in_if.valid <= 1'b0;
  endtask

  // random 64-bit value with some corner-heavy bias
  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver: ready with random holds, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (sink_jitter) begin
        out_if.ready <= ($urandom_range(0, 99) >= 37);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // output check against the oldest expected block
  always @(posedge clk_i) begin
    cipher_t exp_c;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t unexpected beat: exp none act %h_%h", $time, out_if.hi, out_if.lo);
        errors++;
      end else begin
        exp_c = cipher_q.pop_front();
        if (out_if.hi !== exp_c.hi) begin
          $display("%0t cipher_high exp %h act %h", $time, exp_c.hi, out_if.hi);
          errors++;
        end
        if (out_if.lo !== exp_c.lo) begin
          $display("%0t cipher_low exp %h act %h", $time, exp_c.lo, out_if.lo);
          errors++;
        end
      end
    end
  end

  // directed rows: plaintext, and the known answer where there is one
  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    bit          known;
    cipher_t     exp_c;
  } row_t;

  row_t rows [$];

  task automatic run_rows();
    cipher_t got;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        got = encrypt_block(rows[i].hi, rows[i].lo);
        if (got !== rows[i].exp_c) begin
          $display("%0t known answer row %0d exp %h act %h", $time, i, rows[i].exp_c, got);
          errors++;
        end
      end
      send_block(rows[i].hi, rows[i].lo, 1'b0);
    end
    stop_source();
    rows.delete();
  endtask

  initial begin
    logic [63:0]       k [4];
    aes_pkg::key_len_e len;
    errors      = 0;
    cycles      = 0;
    sink_jitter = 1'b0;
    hold_off    = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = aes_pkg::RegKeyLen;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.hi    = '0;
    in_if.lo    = '0;
    cur_len     = aes_pkg::KeyLen128;
    foreach (cur_key[i]) cur_key[i] = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (KeyWait) @(negedge clk_i);

    // after reset: all-zero 128-bit key
    rows.push_back('{64'h0, 64'h0, 1'b1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}});
    rows.push_back('{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, '0});
    rows.push_back('{64'h8000000000000000, 64'h0000000000000001, 1'b0, '0});
    run_rows();

    // standard vectors for each key size
    set_key(aes_pkg::KeyLen128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'hdead, 64'hbeef);
    rows.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                     '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}});
    run_rows();
    set_key(aes_pkg::KeyLen192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h1011121314151617, 64'hffffffffffffffff);
    rows.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                     '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191}});
    run_rows();
    set_key(aes_pkg::KeyLen256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    rows.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                     '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}});
    run_rows();
    // select 3 behaves as 256 bits
    set_key(aes_pkg::KeyLenAlt, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    rows.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                     '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}});
    rows.push_back('{64'h0, 64'hffffffffffffffff, 1'b0, '0});
    run_rows();
    // out-of-range index leaves the key alone
    drain();
    write_bad_idx(64'h0123456789abcdef);
    repeat (KeyWait) @(negedge clk_i);
    rows.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                     '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}});
    run_rows();
    // all-ones keys, 128-bit with unused words ignored
    set_key(aes_pkg::KeyLen128, '1, '1, 64'h0, 64'h0);
    rows.push_back('{64'h0, 64'h0, 1'b0, '0});
    rows.push_back('{'1, '1, 1'b0, '0});
    run_rows();
    set_key(aes_pkg::KeyLen192, '1, '1, '1, 64'h0);
    rows.push_back('{'1, 64'h0, 1'b0, '0});
    run_rows();

    // back-pressure: receiver stops while the sender keeps offering
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++) send_block(rand64(), rand64(), 1'b0);
    stop_source();

    // random phases over key sizes and keys; first phase without idling
    for (int ph = 0; ph < 16; ph++) begin
      len = aes_pkg::key_len_e'($urandom_range(0, 3));
      foreach (k[i]) k[i] = rand64();
      set_key(len, k[0], k[1], k[2], k[3]);
      sink_jitter = (ph != 0);
      if ($urandom_range(0, 3) == 0) write_bad_idx(rand64());
      for (int i = 0; i < 100; i++) send_block(rand64(), rand64(), ph != 0);
      stop_source();
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/aes_pkg.sv
src/aes_if.sv
src/aes_key_exp.sv
src/aes_round.sv
src/aes_block_encrypt.sv
dv/aes_block_encrypt_tb.sv
